>>> rtl/bcomp_pkg.sv
`default_nettype none

package bcomp_pkg;

  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 22;
  localparam int IDX_W   = 3;

  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic [COEFF_W-1:0]        coeff_t;
  typedef logic signed [TEMP_W-1:0]  temp_t;
  typedef logic signed [PRES_W-1:0]  pres_t;
  typedef logic [IDX_W-1:0]          cfg_idx_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } bcomp_reg_t;

  typedef struct packed {
    coeff_t sens;
    coeff_t offset;
    coeff_t sens_temp;
    coeff_t offset_temp;
    coeff_t ref_temp;
    coeff_t temp_slope;
  } bcomp_coeff_t;

  localparam int TEMP_BASE = 2000;

endpackage

`default_nettype wire

>>> rtl/bcomp_in_if.sv
`default_nettype none

interface bcomp_in_if;
  import bcomp_pkg::*;

  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temp;

  modport source (output valid, output raw_pressure, output raw_temp, input ready);
  modport sink (input valid, input raw_pressure, input raw_temp, output ready);
endinterface

`default_nettype wire

>>> rtl/bcomp_out_if.sv
`default_nettype none

interface bcomp_out_if;
  import bcomp_pkg::*;

  logic  valid;
  logic  ready;
  temp_t temp_centideg;
  pres_t pressure_out;

  modport source (output valid, output temp_centideg, output pressure_out, input ready);
  modport sink (input valid, input temp_centideg, input pressure_out, output ready);
endinterface

`default_nettype wire

>>> rtl/bcomp_cfg_if.sv
`default_nettype none

interface bcomp_cfg_if;
  import bcomp_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coeff_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bcomp_pipe.sv
`default_nettype none

module bcomp_pipe (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bcomp_pkg::bcomp_coeff_t coeff,
  bcomp_in_if.sink                    in_ch,
  bcomp_out_if.source                 out_ch
);
  import bcomp_pkg::*;

  localparam int STAGES = 8;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] v_prev;

  // Stage 1: raw pressure and temperature difference.
  raw_t               s1_p_r;
  logic signed [24:0] s1_delta_r;
  logic signed [24:0] s1_delta_nxt;
  // Stage 2: temperature-scaled products.
  raw_t               s2_p_r;
  logic signed [41:0] s2_prod_t_r;
  logic signed [41:0] s2_prod_o_r;
  logic signed [41:0] s2_prod_s_r;
  // Stage 3: temperature, offset and sensitivity.
  raw_t               s3_p_r;
  temp_t              s3_temp_r;
  temp_t              s3_temp_nxt;
  logic signed [35:0] s3_off_r;
  logic signed [35:0] s3_off_nxt;
  logic signed [34:0] s3_sens_r;
  logic signed [34:0] s3_sens_nxt;
  // Stage 4: partial products of raw pressure and sensitivity.
  temp_t              s4_temp_r;
  logic signed [35:0] s4_off_r;
  logic [40:0]        s4_pp_lo_r;
  logic signed [42:0] s4_pp_hi_r;
  // Stage 5: full product.
  temp_t              s5_temp_r;
  logic signed [35:0] s5_off_r;
  logic signed [59:0] s5_prod_r;
  logic signed [59:0] s5_prod_nxt;
  // Stage 6: scaled product.
  temp_t              s6_temp_r;
  logic signed [35:0] s6_off_r;
  logic signed [38:0] s6_q_r;
  logic signed [38:0] s6_q_nxt;
  // Stage 7: offset removed.
  temp_t              s7_temp_r;
  logic signed [39:0] s7_diff_r;
  logic signed [39:0] s7_diff_nxt;
  // Stage 8: result register.
  temp_t              s8_temp_r;
  pres_t              s8_pres_r;
  pres_t              s8_pres_nxt;

  assign v_prev = {v_r[STAGES-2:0], in_ch.valid};

  always_comb begin
    rdy[STAGES] = out_ch.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < STAGES; k++) begin
      en[k]    = rdy[k] && v_prev[k];
      v_nxt[k] = rdy[k] ? v_prev[k] : v_r[k];
    end
  end

  assign in_ch.ready          = rdy[0];
  assign out_ch.valid         = v_r[STAGES-1];
  assign out_ch.temp_centideg = s8_temp_r;
  assign out_ch.pressure_out  = s8_pres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Divisions by powers of two round toward zero, so negative values get a bias first.
  always_comb begin
    logic signed [41:0] t_q;
    logic signed [41:0] o_q;
    logic signed [41:0] s_q;
    logic signed [59:0] p_q;
    logic signed [39:0] d_q;

    s1_delta_nxt = $signed({1'b0, in_ch.raw_temp}) - $signed({1'b0, coeff.ref_temp, 8'h00});

    t_q = (s2_prod_t_r + (s2_prod_t_r[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    s3_temp_nxt = t_q[18:0] + 19'(TEMP_BASE);
    o_q = (s2_prod_o_r + (s2_prod_o_r[41] ? 42'sd127 : 42'sd0)) >>> 7;
    s3_off_nxt = $signed({4'h0, coeff.offset, 16'h0000}) + o_q[35:0];
    s_q = (s2_prod_s_r + (s2_prod_s_r[41] ? 42'sd255 : 42'sd0)) >>> 8;
    s3_sens_nxt = $signed({4'h0, coeff.sens, 15'h0000}) + s_q[34:0];

    s5_prod_nxt = ($signed(60'(s4_pp_hi_r)) <<< 17) + $signed({19'h00000, s4_pp_lo_r});

    p_q = (s5_prod_r + (s5_prod_r[59] ? 60'sd2097151 : 60'sd0)) >>> 21;
    s6_q_nxt = p_q[38:0];

    s7_diff_nxt = 40'(s6_q_r) - 40'(s6_off_r);

    d_q = (s7_diff_r + (s7_diff_r[39] ? 40'sd32767 : 40'sd0)) >>> 15;
    s8_pres_nxt = d_q[21:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_p_r     <= in_ch.raw_pressure;
      s1_delta_r <= s1_delta_nxt;
    end
    if (en[1]) begin
      s2_p_r      <= s1_p_r;
      s2_prod_t_r <= s1_delta_r * $signed({1'b0, coeff.temp_slope});
      s2_prod_o_r <= s1_delta_r * $signed({1'b0, coeff.offset_temp});
      s2_prod_s_r <= s1_delta_r * $signed({1'b0, coeff.sens_temp});
    end
    if (en[2]) begin
      s3_p_r    <= s2_p_r;
      s3_temp_r <= s3_temp_nxt;
      s3_off_r  <= s3_off_nxt;
      s3_sens_r <= s3_sens_nxt;
    end
    if (en[3]) begin
      s4_temp_r  <= s3_temp_r;
      s4_off_r   <= s3_off_r;
      s4_pp_lo_r <= s3_p_r * s3_sens_r[16:0];
      s4_pp_hi_r <= $signed({1'b0, s3_p_r}) * $signed(s3_sens_r[34:17]);
    end
    if (en[4]) begin
      s5_temp_r <= s4_temp_r;
      s5_off_r  <= s4_off_r;
      s5_prod_r <= s5_prod_nxt;
    end
    if (en[5]) begin
      s6_temp_r <= s5_temp_r;
      s6_off_r  <= s5_off_r;
      s6_q_r    <= s6_q_nxt;
    end
    if (en[6]) begin
      s7_temp_r <= s6_temp_r;
      s7_diff_r <= s7_diff_nxt;
    end
    if (en[7]) begin
      s8_temp_r <= s7_temp_r;
      s8_pres_r <= s8_pres_nxt;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted transfer did not reach the first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while the pipeline has a bubble");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !v_r[STAGES-2]) |=> !out_ch.valid)
    else $error("result repeated after its transfer");

endmodule

`default_nettype wire

>>> rtl/barometer_compensation.sv
// Each input transfer passes through the registered pipeline stages before its result is valid at the output.
// Throughput: one sample pair per cycle while the output is taken, set by the fully pipelined datapath.
// The input is ready whenever any pipeline stage is empty or the output is taken.
// Reset (synchronous, active low) clears all stage valid bits and sets all six
// calibration coefficients to zero.
`default_nettype none

module barometer_compensation (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bcomp_in_if.sink    in_ch,
  bcomp_out_if.source out_ch,
  bcomp_cfg_if.sink   cfg_ch
);
  import bcomp_pkg::*;

  bcomp_coeff_t coeff_r;
  bcomp_coeff_t coeff_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    coeff_nxt = coeff_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SENS:        coeff_nxt.sens        = cfg_ch.data;
        REG_OFFSET:      coeff_nxt.offset      = cfg_ch.data;
        REG_SENS_TEMP:   coeff_nxt.sens_temp   = cfg_ch.data;
        REG_OFFSET_TEMP: coeff_nxt.offset_temp = cfg_ch.data;
        REG_REF_TEMP:    coeff_nxt.ref_temp    = cfg_ch.data;
        REG_TEMP_SLOPE:  coeff_nxt.temp_slope  = cfg_ch.data;
        default:         coeff_nxt = coeff_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  bcomp_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .coeff  (coeff_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
  import bcomp_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 9;
  localparam int PHASE_ITEMS    = 45;
  localparam int BURST_ITEMS    = 30;

  localparam longint REF_TEMP_SCALE = 256;
  localparam longint TEMP_SLOPE_DIV = 8388608;
  localparam longint OFF_SCALE      = 65536;
  localparam longint OFF_TEMP_DIV   = 128;
  localparam longint SENS_SCALE     = 32768;
  localparam longint SENS_TEMP_DIV  = 256;
  localparam longint PRES_PROD_DIV  = 2097152;
  localparam longint PRES_FINAL_DIV = 32768;

  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  localparam raw_t RAW_MAX = 24'hFFFFFF;
  localparam coeff_t COEFF_MAX = 16'hFFFF;

  typedef struct packed {
    temp_t temp;
    pres_t pres;
  } comp_result_t;

  localparam comp_result_t AT_RESET = '{temp: temp_t'(TEMP_BASE), pres: '0};

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    cfg_idx_t     idx;
    coeff_t       data;
    raw_t         raw_p;
    raw_t         raw_t_val;
    logic         fixed;
    comp_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bcomp_in_if  in_ch ();
  bcomp_out_if out_ch ();
  bcomp_cfg_if cfg_ch ();

  barometer_compensation uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bcomp_coeff_t cal;
  comp_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  int           fail_count;
  int           hold_requests;

  function automatic comp_result_t compensate(raw_t p_raw, raw_t t_raw, bcomp_coeff_t k);
    longint dt, temp, off, sens, pres;
    comp_result_t r;
    dt   = longint'(t_raw) - longint'(k.ref_temp) * REF_TEMP_SCALE;
    temp = longint'(TEMP_BASE) + (dt * longint'(k.temp_slope)) / TEMP_SLOPE_DIV;
    off  = longint'(k.offset) * OFF_SCALE + (longint'(k.offset_temp) * dt) / OFF_TEMP_DIV;
    sens = longint'(k.sens) * SENS_SCALE + (longint'(k.sens_temp) * dt) / SENS_TEMP_DIV;
    pres = (longint'(p_raw) * sens / PRES_PROD_DIV - off) / PRES_FINAL_DIV;
    r.temp = temp[TEMP_W-1:0];
    r.pres = pres[PRES_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t idx, coeff_t data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic dir_row_t sample_row(raw_t p, raw_t t);
    dir_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.raw_p = p;
    row.raw_t_val = t;
    return row;
  endfunction

  function automatic dir_row_t fixed_row(raw_t p, raw_t t, comp_result_t res);
    dir_row_t row;
    row = sample_row(p, t);
    row.fixed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic raw_t pick_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return RAW_MAX;
    if (r == 2) return raw_t'(longint'(cal.ref_temp) * REF_TEMP_SCALE + $urandom_range(0, 511) - 256);
    return raw_t'($urandom());
  endfunction

  function automatic coeff_t pick_coeff();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return COEFF_MAX;
    return coeff_t'($urandom());
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_coeff(cfg_idx_t idx, coeff_t data, bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SENS:        cal.sens        = data;
      REG_OFFSET:      cal.offset      = data;
      REG_SENS_TEMP:   cal.sens_temp   = data;
      REG_OFFSET_TEMP: cal.offset_temp = data;
      REG_REF_TEMP:    cal.ref_temp    = data;
      REG_TEMP_SLOPE:  cal.temp_slope  = data;
      default: ;
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(raw_t p, raw_t t, bit use_fixed, comp_result_t fixed_res,
                             bit gaps_on);
    int r;
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.raw_pressure <= p;
    in_ch.raw_temp     <= t;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(use_fixed ? fixed_res : compensate(p, t, cal));
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 25);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int steady_left;
    int holds_done;
    int r;
    stall_left = 0;
    steady_left = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = LONG_HOLD;
        steady_left = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        out_ch.ready <= 1'b1;
        steady_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
        end else if (r < 96) begin
          out_ch.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else if (r < 98) begin
          out_ch.ready <= 1'b0;
          stall_left = $urandom_range(8, 30);
        end else begin
          out_ch.ready <= 1'b1;
          steady_left = 40;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    comp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("Unexpected result transfer: temp %0d, pressure %0d",
                               out_ch.temp_centideg, out_ch.pressure_out));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.temp_centideg !== want.temp)
          note_failure($sformatf("temp_centideg mismatch: expected %0d, got %0d",
                                 want.temp, out_ch.temp_centideg));
        if (out_ch.pressure_out !== want.pres)
          note_failure($sformatf("pressure_out mismatch: expected %0d, got %0d",
                                 want.pres, out_ch.pressure_out));
      end
    end
  end

  initial begin
    bit spare;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.raw_pressure <= '0;
    in_ch.raw_temp     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    cal = '0;
    fail_count = 0;
    hold_requests = 0;

    dir_rows.push_back(fixed_row('0, '0, AT_RESET));
    dir_rows.push_back(fixed_row(RAW_MAX, RAW_MAX, AT_RESET));
    dir_rows.push_back(fixed_row(RAW_MAX, '0, AT_RESET));
    dir_rows.push_back(fixed_row('0, RAW_MAX, AT_RESET));
    dir_rows.push_back(cfg_row(REG_SENS, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_OFFSET, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_SENS_TEMP, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_OFFSET_TEMP, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_REF_TEMP, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_TEMP_SLOPE, COEFF_MAX));
    dir_rows.push_back(sample_row('0, '0));
    dir_rows.push_back(sample_row(RAW_MAX, RAW_MAX));
    dir_rows.push_back(sample_row(RAW_MAX, '0));
    dir_rows.push_back(sample_row('0, RAW_MAX));
    dir_rows.push_back(sample_row(RAW_MAX, 24'hFFFF00));
    dir_rows.push_back(cfg_row(REG_REF_TEMP, '0));
    dir_rows.push_back(sample_row(RAW_MAX, RAW_MAX));
    dir_rows.push_back(sample_row(RAW_MAX, '0));
    dir_rows.push_back(cfg_row(REG_SENS, '0));
    dir_rows.push_back(cfg_row(REG_SENS_TEMP, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_TEMP, '0));
    dir_rows.push_back(sample_row(RAW_MAX, '0));
    dir_rows.push_back(cfg_row(REG_SENS, 16'd40127));
    dir_rows.push_back(cfg_row(REG_OFFSET, 16'd36924));
    dir_rows.push_back(cfg_row(REG_SENS_TEMP, 16'd23317));
    dir_rows.push_back(cfg_row(REG_OFFSET_TEMP, 16'd23282));
    dir_rows.push_back(cfg_row(REG_REF_TEMP, 16'd33464));
    dir_rows.push_back(cfg_row(REG_TEMP_SLOPE, 16'd28312));
    dir_rows.push_back(sample_row(24'd9085466, 24'd8569150));
    dir_rows.push_back(cfg_row(REG_SPARE_LO, COEFF_MAX));
    dir_rows.push_back(cfg_row(REG_SPARE_HI, 16'h1234));
    dir_rows.push_back(sample_row(24'd9085466, 24'd8569150));
    // A temperature just below the reference point checks truncation toward zero.
    dir_rows.push_back(cfg_row(REG_REF_TEMP, 16'd1));
    dir_rows.push_back(sample_row(24'd123456, 24'd255));
    dir_rows.push_back(sample_row(RAW_MAX, 24'd257));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) wait_idle();
        write_coeff(dir_rows[i].idx, dir_rows[i].data,
                    i + 1 == dir_rows.size() || dir_rows[i+1].kind != ROW_CFG);
      end else begin
        send_sample(dir_rows[i].raw_p, dir_rows[i].raw_t_val, dir_rows[i].fixed,
                    dir_rows[i].res, 1'b1);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      spare = ($urandom_range(0, 2) == 0);
      for (int k = REG_SENS; k <= REG_TEMP_SLOPE; k++) begin
        write_coeff(cfg_idx_t'(k), (ph == 0) ? coeff_t'(0) : (ph == 1) ? COEFF_MAX : pick_coeff(),
                    !spare && k == REG_TEMP_SLOPE);
      end
      if (spare)
        write_coeff($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, coeff_t'($urandom()),
                    1'b1);
      if (ph == 3) begin
        // The result side stalls for a long stretch while samples keep coming.
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < BURST_ITEMS; i++)
          send_sample(pick_raw(), pick_raw(), 1'b0, '0, 1'b0);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_raw(), pick_raw(), 1'b0, '0, (i % 40) >= 10);
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_idle();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
